[rtl/core/ooktm_pkg.sv]
// ooktm_pkg: shared codes, widths and the sine table builder for the ook tone modulator
// no dependencies; compiled first
package ooktm_pkg;

  // command codes of an input item
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TONE_LEN    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_LEN = 2'd2;

  // fixed field widths
  localparam int unsigned CFG_DATA_BITS = 24;
  localparam int unsigned INC_BITS      = 24;
  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned MAG_BITS      = 15;

  localparam logic [INC_BITS-1:0] PHASE_INC_RESET = 24'd1677722;
  localparam int unsigned TONE_LEN_RESET    = 800;
  localparam int unsigned SPACING_LEN_RESET = 200;

  // pi/2 in q62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  // (a*b) >> s over the full 128-bit product, low 64 bits kept
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  // round(32767 * sin(pi/2 * j / 2^qtr_bits)), taylor series in q62, round half up
  function automatic logic [MAG_BITS-1:0] quarter_sine(int unsigned j, int unsigned qtr_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x    = mul_shift(HALF_PI_Q62, 64'(j), qtr_bits);
    x2   = mul_shift(x, x, 62);
    term = x;
    sum  = x;
    term = mul_shift(term, x2, 62) / 64'd6;   sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd20;  sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd42;  sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd72;  sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd110; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd156; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd210; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd272; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd342; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd420; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd506; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd600; sum = sum + term;
    term = mul_shift(term, x2, 62) / 64'd702; sum = sum - term;
    term = mul_shift(term, x2, 62) / 64'd812; sum = sum + term;
    r = mul_shift(sum, 64'd32767, 61) + 64'd1;
    r = r >> 1;
    return r[MAG_BITS-1:0];
  endfunction

endpackage

[rtl/core/ooktm_if.sv]
// ooktm channel interfaces: input items, result items and configuration writes
// depends on ooktm_pkg for the field widths
interface ooktm_item_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [ooktm_pkg::BYTE_BITS-1:0]   data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface ooktm_result_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ooktm_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    idle;
  logic                                    last_of_byte;
  modport source (output valid, sample, idle, last_of_byte, input ready);
  modport sink   (input valid, sample, idle, last_of_byte, output ready);
endinterface

interface ooktm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [ooktm_pkg::CFG_IDX_BITS-1:0]    index;
  logic [ooktm_pkg::CFG_DATA_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ooktm_sine_rom.sv]
// ooktm_sine_rom: quarter-wave sine magnitude table with a registered read
// depends on ooktm_pkg (quarter_sine builds the contents at elaboration)
module ooktm_sine_rom #(
  parameter int unsigned QTR_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [QTR_BITS:0]                     addr,
  output logic [ooktm_pkg::MAG_BITS-1:0]        mag
);
  import ooktm_pkg::*;

  localparam int unsigned QTR_SIZE = 1 << QTR_BITS;

  // entries 0..QTR_SIZE inclusive, so the mirrored quadrants reach the peak
  logic [MAG_BITS-1:0] rom [QTR_SIZE+1];

  for (genvar j = 0; j <= QTR_SIZE; j++) begin : g_rom
    assign rom[j] = quarter_sine(j, QTR_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= rom[addr];
    end
  end

endmodule

[rtl/core/ook_tone_byte_modulator.sv]
// ook_tone_byte_modulator: on-off keying tone modulator, one byte at a time, lsb first
// depends on ooktm_pkg, ooktm_if and ooktm_sine_rom
//
// A load item (cmd load) takes a byte when no byte is being sent; a load while busy is
// dropped and gives no result. Each tick item gives exactly one result: for each of the
// byte's eight bit slots, tone_len samples of tone (a one bit) or silence (a zero bit),
// then spacing_len zero samples; the tone phase restarts at zero in every slot. A tick
// while idle returns a zero sample with idle set. The block takes one item per clock while
// the output is not stalled. The slot counters and the phase accumulator advance as a tick
// is taken, when its table address and flags are also registered; the quarter-wave sine
// table is then read into a register, and the sign and tone gating land in the output
// register. Bubbles in the pipe let items in while a result waits on the output.
// Configuration writes are always taken (ready is tied high); writes to an index past
// the register list are ignored.
module ook_tone_byte_modulator #(
  parameter int unsigned PHASE_BITS = 24,
  parameter int unsigned TABLE_BITS = 10,
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic           clk,
  input  logic           rst,
  ooktm_item_if.sink     items,
  ooktm_result_if.source results,
  ooktm_cfg_if.sink      cfg
);
  import ooktm_pkg::*;

  localparam int unsigned QTR_BITS = TABLE_BITS - 2;
  localparam int unsigned QTR_SIZE = 1 << QTR_BITS;
  localparam int unsigned SUM_BITS = (PHASE_BITS > INC_BITS) ? PHASE_BITS : INC_BITS;
  localparam int unsigned SLOT_BITS = COUNT_BITS + 1;

  // per-result flags carried down the pipe
  typedef struct packed {
    logic tone;
    logic neg;
    logic idle;
    logic last;
  } flags_t;

  // configuration registers
  logic [INC_BITS-1:0]   phase_inc;
  logic [COUNT_BITS-1:0] tone_len;
  logic [COUNT_BITS-1:0] spacing_len;

  // transmit state
  logic [BYTE_BITS-1:0]  shift_byte, shift_byte_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [SLOT_BITS-1:0]  slot_count, slot_count_next;
  logic [PHASE_BITS-1:0] phase_acc, phase_acc_next;
  logic                  busy, busy_next;

  // pipe registers
  logic                  s1_valid, s2_valid, s3_valid;
  logic [QTR_BITS:0]     s1_addr;
  flags_t                s1_flags, s2_flags;
  logic [MAG_BITS-1:0]   s2_mag;
  logic signed [SAMPLE_BITS-1:0] s3_sample;
  logic                  s3_idle, s3_last;

  logic s1_en, s2_en, s3_en;
  logic in_fire, is_tick;

  // ---------------------------------------------------------------------------
  // configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc   <= PHASE_INC_RESET;
      tone_len    <= COUNT_BITS'(TONE_LEN_RESET);
      spacing_len <= COUNT_BITS'(SPACING_LEN_RESET);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PHASE_INC:   phase_inc   <= cfg.data[INC_BITS-1:0];
        REG_TONE_LEN:    tone_len    <= cfg.data[COUNT_BITS-1:0];
        REG_SPACING_LEN: spacing_len <= cfg.data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipe flow: each stage moves when it is empty or the one after it moves
  assign s3_en = !s3_valid || results.ready;
  assign s2_en = !s2_valid || s3_en;
  assign s1_en = !s1_valid || s2_en;

  assign items.ready = s1_en;
  assign in_fire     = items.valid && items.ready;
  assign is_tick     = (items.cmd == CMD_TICK);

  // ---------------------------------------------------------------------------
  // slot timing and phase
  logic [SLOT_BITS-1:0] slot_len;
  logic [SLOT_BITS-1:0] count_inc;
  logic                 in_tone;
  logic                 slot_end;
  logic                 last_now;
  logic [SUM_BITS-1:0]  phase_sum;

  assign slot_len  = {1'b0, tone_len} + {1'b0, spacing_len};
  assign count_inc = slot_count + SLOT_BITS'(1);
  assign in_tone   = slot_count < {1'b0, tone_len};
  // a slot of zero total length still lasts one sample
  assign slot_end  = count_inc >= slot_len;
  assign last_now  = busy && slot_end && (bit_index == 3'd7);
  assign phase_sum = SUM_BITS'(phase_acc) + SUM_BITS'(phase_inc);

  always_comb begin
    shift_byte_next = shift_byte;
    bit_index_next  = bit_index;
    slot_count_next = slot_count;
    phase_acc_next  = phase_acc;
    busy_next       = busy;
    if (in_fire) begin
      if (!is_tick) begin
        // load is taken only between bytes
        if (!busy) begin
          shift_byte_next = items.data_byte;
          bit_index_next  = 3'd0;
          slot_count_next = '0;
          phase_acc_next  = '0;
          busy_next       = 1'b1;
        end
      end else if (busy) begin
        if (in_tone) begin
          phase_acc_next = phase_sum[PHASE_BITS-1:0];
        end
        if (slot_end) begin
          slot_count_next = '0;
          phase_acc_next  = '0;
          shift_byte_next = shift_byte >> 1;
          if (bit_index == 3'd7) begin
            busy_next      = 1'b0;
            bit_index_next = 3'd0;
          end else begin
            bit_index_next = bit_index + 3'd1;
          end
        end else begin
          slot_count_next = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= '0;
      bit_index  <= '0;
      slot_count <= '0;
      phase_acc  <= '0;
      busy       <= 1'b0;
    end else begin
      shift_byte <= shift_byte_next;
      bit_index  <= bit_index_next;
      slot_count <= slot_count_next;
      phase_acc  <= phase_acc_next;
      busy       <= busy_next;
    end
  end

  // ---------------------------------------------------------------------------
  // table index from the top phase bits
  logic [TABLE_BITS-1:0] k;

  if (PHASE_BITS >= TABLE_BITS) begin : g_k_top
    assign k = phase_acc[PHASE_BITS-1 -: TABLE_BITS];
  end else begin : g_k_pad
    assign k = {phase_acc, {(TABLE_BITS-PHASE_BITS){1'b0}}};
  end

  logic [QTR_BITS-1:0] qtr_j;
  logic [QTR_BITS:0]   rom_addr;
  assign qtr_j    = k[QTR_BITS-1:0];
  // odd quadrants run the quarter table backward
  assign rom_addr = k[QTR_BITS] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, qtr_j})
                                : {1'b0, qtr_j};

  // stage 1: tick snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_fire && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_addr       <= rom_addr;
      s1_flags.tone <= busy && in_tone && shift_byte[0];
      s1_flags.neg  <= k[TABLE_BITS-1];
      s1_flags.idle <= !busy;
      s1_flags.last <= last_now;
    end
  end

  // stage 2: registered table read
  ooktm_sine_rom #(
    .QTR_BITS(QTR_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (s2_en),
    .addr (s1_addr),
    .mag  (s2_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_flags <= s1_flags;
    end
  end

  // stage 3: sign, gating, output register
  logic signed [SAMPLE_BITS-1:0] mag_s;
  logic signed [SAMPLE_BITS-1:0] sample_next;
  assign mag_s = signed'({1'b0, s2_mag});

  always_comb begin
    if (!s2_flags.tone) begin
      sample_next = '0;
    end else if (s2_flags.neg) begin
      sample_next = -mag_s;
    end else begin
      sample_next = mag_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_sample <= sample_next;
      s3_idle   <= s2_flags.idle;
      s3_last   <= s2_flags.last;
    end
  end

  assign results.valid        = s3_valid;
  assign results.sample       = s3_sample;
  assign results.idle         = s3_idle;
  assign results.last_of_byte = s3_last;

endmodule

[rtl/core/ooktm_checker.sv]
// ooktm_checker: port-level assertions for the ook tone modulator, bound to the top level
// depends on ooktm_pkg for field widths
module ooktm_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    res_valid,
  input logic                                    res_ready,
  input logic signed [ooktm_pkg::SAMPLE_BITS-1:0] res_sample,
  input logic                                    res_idle,
  input logic                                    res_last
);
  import ooktm_pkg::*;

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sample) && $stable(res_idle)
                                && $stable(res_last))
    else $error("stalled result changed");

  // idle ticks are silent and never end a byte
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_idle |-> res_sample == '0 && !res_last)
    else $error("idle result not silent");

  // the sine never reaches the most negative code
  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
    else $error("sample out of range");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind ook_tone_byte_modulator ooktm_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_sample (results.sample),
  .res_idle   (results.idle),
  .res_last   (results.last_of_byte)
);
